[hw/rtl/olg_pkg.sv]
// Shared types and constants for the octree leaf grouper.
// Used by olg_front, olg_back and octree_leaf_grouper; depends on nothing.
`default_nettype none

package olg_pkg;

    localparam int KEY_W  = 64;
    localparam int LVL_W  = 5;
    localparam int ADDR_W = 3;

    // Register indexes (paddr[2])
    localparam logic REG_BASE_INDEX = 1'b0;
    localparam logic REG_TOP_LEVEL  = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             is_last;
    } t_in_req;

    typedef struct packed {
        logic [31:0]      leaf_start;
        logic [3:0]       leaf_length;
        logic [LVL_W-1:0] leaf_level;
        logic             forced_cut;
        logic             last_leaf;
    } t_out_req;

    typedef struct packed {
        logic [31:0]      base_index;
        logic [LVL_W-1:0] top_level;
    } t_cfg;

    // 3-bit octant code of a key at a tree level
    function automatic logic [2:0] triplet(input logic [KEY_W-1:0] k,
                                           input logic [LVL_W-1:0] lvl);
        logic [6:0] sh;
        sh = {2'b00, lvl} * 7'd3;
        return 3'(k >> sh);
    endfunction

endpackage

`default_nettype wire

[hw/rtl/octree_leaf_grouper.sv]
// Top level of the octree leaf grouper: APB registers, front queue, back end.
// Depends on olg_pkg, olg_front and olg_back.
`default_nettype none

// Splits a node's curve-ordered keys into leaves of at most MAX_LEAF keys and
// reports each leaf's start, length and level. Keys enter a two-entry queue
// and are taken one per cycle while the window fills. Once the window
// holds MAX_LEAF+1 keys, or on the node's last key, each leaf is found by a
// level search (one level per cycle), its keys are dropped from the window
// (one-entry shift per cycle) and the next start level is set; the last leaf
// of a node skips the shift. No clearing pass after reset.

module octree_leaf_grouper #(
    parameter int MAX_LEAF   = 8,
    parameter int KEY_LEVELS = 21
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_valid,
    output logic                       o_ready,
    input  olg_pkg::t_in_req           i_req,
    output logic                       o_valid,
    input  wire                        i_ready,
    output olg_pkg::t_out_req          o_res,
    input  wire                        psel,
    input  wire                        penable,
    input  wire                        pwrite,
    input  wire [olg_pkg::ADDR_W-1:0]  paddr,
    input  wire [31:0]                 pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    olg_pkg::t_cfg    r_cfg;
    olg_pkg::t_in_req q_req;
    logic q_valid, q_pop, wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            case (paddr[2])
                olg_pkg::REG_BASE_INDEX: r_cfg.base_index <= pwdata;
                olg_pkg::REG_TOP_LEVEL:  r_cfg.top_level  <= pwdata[olg_pkg::LVL_W-1:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (paddr[2])
            olg_pkg::REG_BASE_INDEX: prdata = r_cfg.base_index;
            olg_pkg::REG_TOP_LEVEL:  prdata = 32'(r_cfg.top_level);
            default:                 prdata = '0;
        endcase
    end

    olg_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_req     (i_req),
        .o_q_valid (q_valid),
        .i_q_pop   (q_pop),
        .o_q_req   (q_req)
    );

    olg_back #(
        .MAX_LEAF   (MAX_LEAF),
        .KEY_LEVELS (KEY_LEVELS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .o_q_pop   (q_pop),
        .i_q_req   (q_req),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_res     (o_res)
    );

endmodule

`default_nettype wire

[hw/rtl/olg_front.sv]
// Front end of the leaf grouper: two-entry request queue that decouples
// the key stream from the leaf search. Depends on olg_pkg.
`default_nettype none

module olg_front (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    output logic            o_ready,
    input  olg_pkg::t_in_req i_req,
    output logic            o_q_valid,
    input  wire             i_q_pop,
    output olg_pkg::t_in_req o_q_req
);

    olg_pkg::t_in_req r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready   = (r_cnt != 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_req   = r_mem[r_rp];
    assign push      = i_valid && o_ready;
    assign pop       = i_q_pop && o_q_valid;

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_req;
        end
    end

    // Pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count overflow");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd1) |-> (r_wp != r_rp)) else $error("queue pointers out of step");
    a_full_eq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 2'd1) |-> (r_wp == r_rp)) else $error("queue pointers out of step");

endmodule

`default_nettype wire

[hw/rtl/olg_back.sv]
// Back end of the leaf grouper: key window, level search, window shift
// and leaf result register. Depends on olg_pkg.
`default_nettype none

module olg_back #(
    parameter int MAX_LEAF   = 8,
    parameter int KEY_LEVELS = 21
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  olg_pkg::t_cfg    i_cfg,
    input  wire              i_q_valid,
    output logic             o_q_pop,
    input  olg_pkg::t_in_req i_q_req,
    output logic             o_valid,
    input  wire              i_ready,
    output olg_pkg::t_out_req o_res
);

    localparam int W       = MAX_LEAF + 1;
    localparam int CW      = $clog2(W + 1);
    localparam int DEEPEST = KEY_LEVELS - 1;
    localparam int LW      = olg_pkg::LVL_W;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SEARCH = 4'b0010,
        ST_SHIFT  = 4'b0100,
        ST_NEXT   = 4'b1000
    } t_state;

    t_state r_state;
    logic [olg_pkg::KEY_W-1:0] r_win [W];
    logic [olg_pkg::KEY_W-1:0] r_prev;
    logic [CW-1:0]  r_fill, r_drop;
    logic [31:0]    r_head;
    logic [LW-1:0]  r_lvl;
    logic           r_first, r_last;
    logic           r_out_valid;
    olg_pkg::t_out_req r_out;

    logic [LW:0]    start_raw;
    logic [LW-1:0]  start_lvl, nxt_lvl;
    logic [2:0]     t0;
    logic [CW-1:0]  run_n, len;
    logic           over, deepest, done, final_leaf, out_free, pop;

    // Start level of a node, clamped to the deepest level
    assign start_raw = {1'b0, i_cfg.top_level} + {{LW{1'b0}}, 1'b1};
    assign start_lvl = (int'(start_raw) > DEEPEST) ? LW'(DEEPEST) : start_raw[LW-1:0];

    // Run of keys sharing the head's triplet at the current level
    always_comb begin
        t0    = olg_pkg::triplet(r_win[0], r_lvl);
        run_n = r_fill;
        for (int i = W - 1; i >= 1; i--) begin
            if ((CW'(i) < r_fill) && (olg_pkg::triplet(r_win[i], r_lvl) != t0)) begin
                run_n = CW'(i);
            end
        end
    end

    assign over       = (int'(run_n) > MAX_LEAF);
    assign deepest    = (int'(r_lvl) >= DEEPEST);
    assign done       = !over || deepest;
    assign len        = over ? CW'(MAX_LEAF) : run_n;
    assign final_leaf = r_last && (len == r_fill);
    assign out_free   = !r_out_valid || i_ready;

    // First level where new head and previous key part ways
    always_comb begin
        nxt_lvl = LW'(DEEPEST);
        for (int l = KEY_LEVELS - 2; l >= 0; l--) begin
            if ((LW'(l) >= start_lvl) &&
                (olg_pkg::triplet(r_win[0], LW'(l)) != olg_pkg::triplet(r_prev, LW'(l)))) begin
                nxt_lvl = LW'(l);
            end
        end
    end

    assign pop     = (r_state == ST_IDLE) && i_q_valid;
    assign o_q_pop = pop;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    // Window storage and result payload
    always_ff @(posedge i_clk) begin
        if (pop && (int'(r_fill) < W)) begin
            r_win[r_fill[$clog2(W)-1:0]] <= i_q_req.key;
        end
        if (r_state == ST_SHIFT) begin
            r_prev <= r_win[0];
            for (int i = 0; i < W - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
        end
        if ((r_state == ST_SEARCH) && done && out_free) begin
            r_out.leaf_start  <= i_cfg.base_index + r_head;
            r_out.leaf_length <= 4'(len);
            r_out.leaf_level  <= r_lvl;
            r_out.forced_cut  <= over;
            r_out.last_leaf   <= final_leaf;
        end
    end

    // Control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_drop      <= '0;
            r_head      <= '0;
            r_lvl       <= '0;
            r_first     <= 1'b1;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ready) r_out_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        if (r_first) r_lvl <= start_lvl;
                        r_first <= 1'b0;
                        r_last  <= i_q_req.is_last;
                        if (int'(r_fill) < W) r_fill <= r_fill + CW'(1);
                        if ((int'(r_fill) + 1 >= W) || i_q_req.is_last) begin
                            r_state <= ST_SEARCH;
                        end
                    end
                end
                ST_SEARCH: begin
                    if (!done) begin
                        r_lvl <= r_lvl + LW'(1);
                    end else if (out_free) begin
                        r_out_valid <= 1'b1;
                        if (final_leaf) begin
                            r_fill  <= '0;
                            r_head  <= '0;
                            r_first <= 1'b1;
                            r_last  <= 1'b0;
                            r_state <= ST_IDLE;
                        end else begin
                            r_head  <= r_head + 32'(len);
                            r_drop  <= len;
                            r_state <= ST_SHIFT;
                        end
                    end
                end
                ST_SHIFT: begin
                    r_fill <= r_fill - CW'(1);
                    r_drop <= r_drop - CW'(1);
                    if (r_drop == CW'(1)) r_state <= ST_NEXT;
                end
                ST_NEXT: begin
                    r_lvl <= nxt_lvl;
                    if ((int'(r_fill) == W) || r_last) r_state <= ST_SEARCH;
                    else                               r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_fill_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_fill) <= W) else $error("window overfilled");
    a_lvl_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_lvl) <= DEEPEST) else $error("search level beyond deepest");
    a_shift_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SHIFT) |-> (r_drop != '0 && r_fill != '0))
        else $error("shift without entries");
    a_search_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEARCH) |-> (r_fill != '0)) else $error("search on empty window");

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for octree_leaf_grouper: drives curve keys and APB
// register writes, predicts every leaf, and checks results in order.
// Depends on olg_pkg and the octree_leaf_grouper RTL.
`default_nettype none

module tb;

    localparam int LEAF_MAX  = 8;
    localparam int LEVELS    = 21;
    localparam int DEEP_LVL  = LEVELS - 1;
    localparam int WIN_SZ    = LEAF_MAX + 1;
    localparam longint CYCLE_LIMIT = 400000;

    // Idle-pattern phases
    typedef enum int { PH_NONE, PH_SEND, PH_RECV, PH_BOTH } t_phase;

    // Expected-leaf tracker: holds its own grouping state and a queue of leaves
    class leaf_board;
        logic [31:0]      base_idx;
        logic [olg_pkg::LVL_W-1:0] top_lvl;
        logic [63:0]      win [WIN_SZ];
        int               fill;
        logic [31:0]      head;
        int               lvl_start;
        logic [63:0]      prev_key;
        bit               node_open;
        olg_pkg::t_out_req leaves [$];
        int               errors;

        function new();
            base_idx = '0; top_lvl = '0; fill = 0; head = '0;
            lvl_start = 0; prev_key = '0; node_open = 0; errors = 0;
        endfunction

        function int first_level();
            int s;
            s = int'(top_lvl) + 1;
            return (s > DEEP_LVL) ? DEEP_LVL : s;
        endfunction

        function logic [2:0] oct(logic [63:0] k, int l);
            return 3'((k >> (3 * l)) & 64'h7);
        endfunction

        // Note an accepted key and queue the leaves it releases
        function void note_key(olg_pkg::t_in_req r);
            int l, n;
            bit cut, fin;
            olg_pkg::t_out_req o;
            if (!node_open) begin
                lvl_start = first_level();
                node_open = 1;
            end
            if (lvl_start > DEEP_LVL) lvl_start = DEEP_LVL;
            if (fill < WIN_SZ) begin
                win[fill] = r.key;
                fill++;
            end
            while (fill > 0 && (fill == WIN_SZ || r.is_last)) begin
                l = lvl_start;
                cut = 0;
                forever begin
                    n = 1;
                    while (n < fill && oct(win[n], l) == oct(win[0], l)) n++;
                    if (n <= LEAF_MAX) break;
                    if (l >= DEEP_LVL) begin
                        n = LEAF_MAX;
                        cut = 1;
                        break;
                    end
                    l++;
                end
                fin = r.is_last && n == fill;
                o.leaf_start  = base_idx + head;
                o.leaf_length = 4'(n);
                o.leaf_level  = olg_pkg::LVL_W'(l);
                o.forced_cut  = cut;
                o.last_leaf   = fin;
                leaves.push_back(o);
                prev_key = win[n-1];
                for (int i = 0; i < fill - n; i++) win[i] = win[i+n];
                fill -= n;
                head += 32'(n);
                if (fin) begin
                    fill = 0;
                    head = '0;
                    node_open = 0;
                    break;
                end
                l = first_level();
                while (l < DEEP_LVL && oct(win[0], l) == oct(prev_key, l)) l++;
                lvl_start = l;
            end
        endfunction

        // Compare one accepted leaf with the oldest expectation
        function void check_leaf(olg_pkg::t_out_req a);
            olg_pkg::t_out_req e;
            if (leaves.size() == 0) begin
                $error("unexpected leaf start=%0d", a.leaf_start);
                errors++;
                return;
            end
            e = leaves.pop_front();
            if (a.leaf_start !== e.leaf_start) begin
                $error("leaf_start exp %0d got %0d", e.leaf_start, a.leaf_start);
                errors++;
            end
            if (a.leaf_length !== e.leaf_length) begin
                $error("leaf_length exp %0d got %0d", e.leaf_length, a.leaf_length);
                errors++;
            end
            if (a.leaf_level !== e.leaf_level) begin
                $error("leaf_level exp %0d got %0d", e.leaf_level, a.leaf_level);
                errors++;
            end
            if (a.forced_cut !== e.forced_cut) begin
                $error("forced_cut exp %0d got %0d", e.forced_cut, a.forced_cut);
                errors++;
            end
            if (a.last_leaf !== e.last_leaf) begin
                $error("last_leaf exp %0d got %0d", e.last_leaf, a.last_leaf);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    olg_pkg::t_in_req  i_req;
    logic              o_valid;
    logic              i_ready;
    olg_pkg::t_out_req o_res;
    logic              psel, penable, pwrite;
    logic [olg_pkg::ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    leaf_board board;
    t_phase    phase;
    bit        hold_recv;
    longint    cycles;
    int        gap_pct;

    octree_leaf_grouper u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_req(i_req),
        .o_valid(o_valid), .i_ready(i_ready), .o_res(o_res),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // Timeout watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // Receiver: random stalls per phase, plus a long hold-off on request
    initial begin
        i_ready = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) board.check_leaf(o_res);
            if (hold_recv)
                i_ready <= 0;
            else if (phase == PH_RECV || phase == PH_BOTH)
                i_ready <= ($urandom_range(99) >= 73);
            else
                i_ready <= 1;
        end
    end

    // Long receiver hold-off counted in its own process
    task automatic hold_off(int n);
        hold_recv = 1;
        repeat (n) @(posedge i_clk);
        hold_recv = 0;
    endtask

    // Register write: setup then access cycle
    task automatic reg_write(logic idx, logic [31:0] val);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        if (idx == olg_pkg::REG_BASE_INDEX) board.base_idx = val;
        else board.top_lvl = val[olg_pkg::LVL_W-1:0];
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    // Offer one key request and wait for acceptance
    task automatic send_key(logic [63:0] k, logic lst);
        while ((phase == PH_SEND || phase == PH_BOTH) && $urandom_range(99) < 73) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_req.key <= k;
        i_req.is_last <= lst;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        board.note_key('{key: k, is_last: lst});
    endtask

    // Wait for all leaves plus the block's tail latency
    task automatic drain();
        i_valid <= 0;
        while (board.leaves.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    // Node of n keys sharing a random prefix above a chosen level
    task automatic send_node(int n, int split_lvl);
        logic [63:0] k, pre;
        pre = {$urandom, $urandom};
        for (int i = 0; i < n; i++) begin
            k = {$urandom, $urandom};
            if (split_lvl < 21)
                k = (pre & ~((64'd1 << (3 * split_lvl)) - 1)) |
                    (k & ((64'd1 << (3 * split_lvl)) - 1));
            send_key(k, i == n - 1);
        end
    endtask

    initial begin
        board = new();
        phase = PH_NONE; hold_recv = 0;
        i_valid = 0; i_req = '0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        i_rst_n = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: extremes, equal keys (forced cuts), one-key node, clamp
        send_key(64'h0, 1);
        send_key(64'hFFFF_FFFF_FFFF_FFFF, 1);
        for (int i = 0; i < 11; i++) send_key(64'h1234_5678_9ABC_DEF0, i == 10);
        for (int i = 0; i < 6; i++) send_key(64'(i) << 60, i == 5);
        drain();
        reg_write(olg_pkg::REG_BASE_INDEX, 32'hFFFF_FFFC);
        reg_write(olg_pkg::REG_TOP_LEVEL, 5'd19);
        for (int i = 0; i < 5; i++) send_key({$urandom, $urandom}, i == 4);
        drain();
        reg_write(olg_pkg::REG_TOP_LEVEL, 5'd31);
        send_node(3, 21);
        drain();

        // Random phases with varied settings
        for (int p = 0; p < 4; p++) begin
            phase = t_phase'(p);
            reg_write(olg_pkg::REG_BASE_INDEX, (p == 3) ? 32'hFFFF_FFFF : $urandom);
            reg_write(olg_pkg::REG_TOP_LEVEL, (p == 0) ? 5'd0 : 5'($urandom_range(31)));
            if (p == 1) fork hold_off(600); join_none
            for (int nd = 0; nd < 4; nd++)
                send_node($urandom_range(1, 12), $urandom_range(0, 21));
            send_key({$urandom, $urandom}, $urandom_range(1));
            drain();
        end

        if (board.errors == 0 && board.leaves.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

`default_nettype wire
